// ----- rtl/smc_pkg.sv -----
// Package: opcodes, status codes, command codes, sequencer states and opcode tables.
`default_nettype none
package smc_pkg;
    localparam int unsigned NUM_OPS = 27;

    typedef enum logic [1:0] {
        CMD_WR_CODE = 2'd0,
        CMD_WR_DATA = 2'd1,
        CMD_EXEC    = 2'd2,
        CMD_RESTART = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_QUIT   = 3'd1,
        ST_DIVZ   = 3'd2,
        ST_BADOP  = 3'd3,
        ST_STACK  = 3'd4,
        ST_ADDR   = 3'd5,
        ST_HALTED = 3'd6
    } t_status;

    typedef enum logic [4:0] {
        OP_QUIT = 5'd0,  OP_AND = 5'd1,  OP_OR = 5'd2,   OP_NOT = 5'd3,
        OP_INC = 5'd4,   OP_DEC = 5'd5,  OP_LOAD = 5'd6, OP_STORE = 5'd7,
        OP_LIT = 5'd8,   OP_LDI = 5'd9,  OP_STI = 5'd10, OP_ADD = 5'd11,
        OP_SUB = 5'd12,  OP_MULT = 5'd13, OP_DIV = 5'd14, OP_NEG = 5'd15,
        OP_EQ = 5'd16,   OP_LT = 5'd17,  OP_GT = 5'd18,  OP_NE = 5'd19,
        OP_LE = 5'd20,   OP_GE = 5'd21,  OP_BR = 5'd22,  OP_BRL = 5'd23,
        OP_BRF = 5'd24,  OP_OUT = 5'd25, OP_IN = 5'd26
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_DECODE,
        S_READ2,
        S_IMM,
        S_EXEC,
        S_DMEM,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0] pops;
        logic       push;
        logic       imm;
    } t_opinfo;

    function automatic t_opinfo op_info(input logic [4:0] op);
        t_opinfo r;
        r = '{pops: 2'd0, push: 1'b0, imm: 1'b0};
        unique case (op)
            OP_QUIT:                 r = '{2'd0, 1'b0, 1'b0};
            OP_AND, OP_OR:           r = '{2'd2, 1'b1, 1'b0};
            OP_NOT:                  r = '{2'd1, 1'b1, 1'b0};
            OP_INC, OP_DEC:          r = '{2'd1, 1'b1, 1'b1};
            OP_LOAD, OP_LIT:         r = '{2'd0, 1'b1, 1'b1};
            OP_STORE:                r = '{2'd1, 1'b0, 1'b1};
            OP_LDI, OP_NEG:          r = '{2'd1, 1'b1, 1'b0};
            OP_STI, OP_BRF:          r = '{2'd2, 1'b0, 1'b0};
            OP_ADD, OP_SUB, OP_MULT, OP_DIV, OP_EQ, OP_LT, OP_GT, OP_NE, OP_LE, OP_GE:
                                     r = '{2'd2, 1'b1, 1'b0};
            OP_BR, OP_OUT:           r = '{2'd1, 1'b0, 1'b0};
            OP_BRL:                  r = '{2'd0, 1'b0, 1'b1};
            OP_IN:                   r = '{2'd0, 1'b1, 1'b0};
            default:                 r = '{2'd0, 1'b0, 1'b0};
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// ----- rtl/smc_divider.sv -----
// Multicycle signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module smc_divider #(
    parameter int unsigned WORD_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [WORD_WIDTH-1:0] i_dividend,
    input  wire logic [WORD_WIDTH-1:0] i_divisor,
    output logic                       o_done,
    output logic [WORD_WIDTH-1:0]      o_quotient
);
    localparam int unsigned CW = $clog2(WORD_WIDTH + 1);

    logic [WORD_WIDTH-1:0] r_rem, r_quo, r_den;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy, r_neg;
    logic [WORD_WIDTH:0]   w_trial;
    logic [WORD_WIDTH-1:0] w_na, w_nb;

    assign w_na = i_dividend[WORD_WIDTH-1] ? -i_dividend : i_dividend;
    assign w_nb = i_divisor[WORD_WIDTH-1] ? -i_divisor : i_divisor;
    assign w_trial = {r_rem[WORD_WIDTH-1:0], r_quo[WORD_WIDTH-1]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_quo  <= w_na;
                r_den  <= w_nb;
                r_neg  <= i_dividend[WORD_WIDTH-1] ^ i_divisor[WORD_WIDTH-1];
                r_cnt  <= CW'(WORD_WIDTH);
            end else if (r_busy) begin
                if (!w_trial[WORD_WIDTH]) begin
                    r_rem <= w_trial[WORD_WIDTH-1:0];
                    r_quo <= {r_quo[WORD_WIDTH-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[WORD_WIDTH-2:0], r_quo[WORD_WIDTH-1]};
                    r_quo <= {r_quo[WORD_WIDTH-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient = r_neg ? -r_quo : r_quo;
endmodule
`default_nettype wire

// ----- rtl/stack_machine_core.sv -----
// Top level: stack machine with code, data and operand stack memories and a sequencer.
//
// Input channel (i_valid/o_stall): command, address, value. Commands write a
// code word, write a data word, execute one instruction or restart.
// Output channel (o_valid/i_stall): one result word per input word with
// out_valid, out_value, status, program_counter and stack_depth.
// Writes and restart go from fetch straight to the result. An execute
// runs code fetch, decode with top-of-stack read, second stack read,
// immediate fetch where the opcode has one, execute and write back; a
// data memory read adds a step and a div waits for the bit-serial
// divider. A bad opcode or stack fault ends after decode, an execute
// while halted after fetch. The next word is taken in the cycle its
// result is taken. Each memory has a registered read and the stack
// memory one read port, which set the order of these steps.
// Reset clears pc, stack pointer, halted flag and handshake state; the
// memories hold garbage until written. While the receiver stalls, the
// result is held and the next input word is not taken.
`default_nettype none
module stack_machine_core #(
    parameter int unsigned CODE_DEPTH  = 1024,
    parameter int unsigned DATA_DEPTH  = 1024,
    parameter int unsigned STACK_DEPTH = 128,
    parameter int unsigned WORD_WIDTH  = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [9:0]  i_address,
    input  wire logic signed [31:0] i_value,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_out_valid,
    output logic signed [31:0] o_out_value,
    output logic [2:0]       o_status,
    output logic [9:0]       o_program_counter,
    output logic [7:0]       o_stack_depth
);
    import smc_pkg::*;

    localparam int unsigned CA = $clog2(CODE_DEPTH);
    localparam int unsigned DA = $clog2(DATA_DEPTH);
    localparam int unsigned SA = $clog2(STACK_DEPTH);
    localparam int unsigned SP = $clog2(STACK_DEPTH + 1);
    localparam int unsigned W  = WORD_WIDTH;

    logic [W-1:0] code_mem [CODE_DEPTH];
    logic [W-1:0] data_mem [DATA_DEPTH];
    logic [W-1:0] stk_mem  [STACK_DEPTH];

    t_state r_state, n_state;
    logic [CA-1:0] r_pc, n_pc;
    logic [SP-1:0] r_sp, n_sp;
    logic r_halt, n_halt;
    logic [1:0] r_cmd;
    logic [9:0] r_addr;
    logic [W-1:0] r_val;
    logic [4:0] r_op, n_op;
    logic [W-1:0] r_top, n_top, r_under, n_under, r_imm, n_imm;
    logic r_oval, n_oval;
    logic [W-1:0] r_outv, n_outv;
    logic [2:0] r_stat, n_stat;
    logic r_ovalid, n_ovalid;

    logic [W-1:0] r_cq, r_dq, r_sq;
    logic c_re, d_re, d_we, s_re, s_we;
    logic [CA-1:0] c_ra;
    logic [DA-1:0] d_a;
    logic [W-1:0] d_wd, s_wd;
    logic [SA-1:0] s_ra, s_wa;

    logic div_start, div_done;
    logic [W-1:0] div_q;
    logic [W-1:0] mul_r;
    t_opinfo info;
    logic signed [W-1:0] st, su;
    logic w_in_ok;

    smc_divider #(.WORD_WIDTH(W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(r_under), .i_divisor(r_top),
        .o_done(div_done), .o_quotient(div_q)
    );

    // memories
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_in_ok && i_command == CMD_WR_CODE
            && 32'(i_address) < CODE_DEPTH)
            code_mem[CA'(i_address)] <= W'(i_value);
        if (c_re) r_cq <= code_mem[c_ra];
    end
    always_ff @(posedge i_clk) begin
        if (d_we) data_mem[d_a] <= d_wd;
        if (d_re) r_dq <= data_mem[d_a];
    end
    always_ff @(posedge i_clk) begin
        if (s_we) stk_mem[s_wa] <= s_wd;
        if (s_re) r_sq <= stk_mem[s_ra];
    end

    assign w_in_ok = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE) || (r_ovalid && i_stall);
    assign info = op_info(r_op);
    assign st = r_top;
    assign su = r_under;
    assign mul_r = r_under * r_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pc     <= '0;
            r_sp     <= '0;
            r_halt   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pc     <= n_pc;
            r_sp     <= n_sp;
            r_halt   <= n_halt;
            r_ovalid <= n_ovalid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_in_ok) begin
            r_cmd  <= i_command;
            r_addr <= i_address;
            r_val  <= W'(i_value);
        end
        r_op    <= n_op;
        r_top   <= n_top;
        r_under <= n_under;
        r_imm   <= n_imm;
        r_oval  <= n_oval;
        r_outv  <= n_outv;
        r_stat  <= n_stat;
    end

    function automatic logic addr_ok(input logic [W-1:0] a, input int unsigned depth);
        return !a[W-1] && (64'(a) < 64'(depth));
    endfunction

    always_comb begin
        logic [SP:0] newsp;
        logic [CA-1:0] tgt;
        logic [W-1:0] res;
        logic take;
        t_opinfo dinfo;
        n_state = r_state; n_pc = r_pc; n_sp = r_sp; n_halt = r_halt;
        n_op = r_op; n_top = r_top; n_under = r_under; n_imm = r_imm;
        n_oval = r_oval; n_outv = r_outv; n_stat = r_stat; n_ovalid = r_ovalid;
        c_re = 1'b0; c_ra = r_pc + 1'b1;
        d_re = 1'b0; d_we = 1'b0; d_a = DA'(r_addr); d_wd = r_val;
        s_re = 1'b0; s_we = 1'b0; s_ra = SA'(r_sp - 1'b1); s_wa = '0; s_wd = '0;
        div_start = 1'b0;
        newsp = '0; tgt = '0; res = '0; take = 1'b0;
        dinfo = op_info(r_cq[4:0]);
        if (r_ovalid && !i_stall) n_ovalid = 1'b0;
        unique case (r_state)
            S_IDLE: if (w_in_ok) n_state = S_FETCH;
            S_FETCH: begin
                n_oval = 1'b0; n_outv = '0; n_stat = ST_OK;
                priority case (r_cmd)
                    CMD_WR_CODE: n_state = S_DONE;
                    CMD_WR_DATA: begin
                        d_we = 32'(r_addr) < DATA_DEPTH;
                        n_state = S_DONE;
                    end
                    CMD_RESTART: begin
                        n_pc = '0; n_sp = '0; n_halt = 1'b0; n_state = S_DONE;
                    end
                    default: begin
                        if (r_halt) begin
                            n_stat = ST_HALTED; n_state = S_DONE;
                        end else begin
                            c_re = 1'b1; n_pc = r_pc + 1'b1;
                            s_re = 1'b1; n_state = S_DECODE;
                        end
                    end
                endcase
            end
            S_DECODE: begin
                n_top = r_sq;
                if (r_cq >= W'(NUM_OPS)) begin
                    n_stat = ST_BADOP; n_state = S_DONE;
                end else begin
                    n_op = r_cq[4:0];
                    newsp = (SP+1)'(r_sp) - (SP+1)'(dinfo.pops) + (SP+1)'(dinfo.push);
                    if ((SP+1)'(r_sp) < (SP+1)'(dinfo.pops)
                        || newsp > (SP+1)'(STACK_DEPTH)) begin
                        n_stat = ST_STACK; n_state = S_DONE;
                    end else begin
                        s_re = 1'b1; s_ra = SA'(r_sp - 2'd2);
                        n_state = S_READ2;
                    end
                end
            end
            S_READ2: begin
                n_under = r_sq;
                if (info.imm) begin
                    c_re = 1'b1; n_pc = r_pc + 1'b1; n_state = S_IMM;
                end else n_state = S_EXEC;
            end
            S_IMM: begin
                n_imm = r_cq;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                newsp = (SP+1)'(r_sp) - (SP+1)'(info.pops) + (SP+1)'(info.push);
                n_state = S_DONE;
                unique case (r_op)
                    OP_QUIT: begin n_halt = 1'b1; n_stat = ST_QUIT; end
                    OP_AND: res = W'((r_under != 0) && (r_top != 0));
                    OP_OR:  res = W'((r_under != 0) || (r_top != 0));
                    OP_NOT: res = W'(r_top == 0);
                    OP_INC: res = r_top + r_imm;
                    OP_DEC: res = r_top - r_imm;
                    OP_LOAD, OP_STORE, OP_LDI, OP_STI: begin
                        logic [W-1:0] a;
                        a = (r_op == OP_LOAD || r_op == OP_STORE) ? r_imm :
                            (r_op == OP_LDI) ? r_top : r_under;
                        if (!addr_ok(a, DATA_DEPTH)) begin
                            n_halt = 1'b1; n_stat = ST_ADDR;
                        end else begin
                            d_a = DA'(a);
                            if (r_op == OP_STORE || r_op == OP_STI) begin
                                d_we = 1'b1; d_wd = r_top; n_sp = SP'(newsp);
                            end else begin
                                d_re = 1'b1; n_state = S_DMEM;
                            end
                        end
                    end
                    OP_LIT: res = r_imm;
                    OP_ADD: res = r_under + r_top;
                    OP_SUB: res = r_under - r_top;
                    OP_MULT: res = mul_r;
                    OP_DIV: begin
                        if (r_top == 0) begin
                            n_sp = r_sp - 1'b1; n_halt = 1'b1; n_stat = ST_DIVZ;
                        end else begin
                            div_start = 1'b1; n_state = S_DIV;
                        end
                    end
                    OP_NEG: res = -r_top;
                    OP_EQ: res = W'(su == st);
                    OP_LT: res = W'(su < st);
                    OP_GT: res = W'(su > st);
                    OP_NE: res = W'(su != st);
                    OP_LE: res = W'(su <= st);
                    OP_GE: res = W'(su >= st);
                    OP_BR, OP_BRL, OP_BRF: begin
                        logic [W-1:0] t;
                        t = (r_op == OP_BRL) ? r_imm : r_top;
                        take = (r_op != OP_BRF) || (r_under == 0);
                        tgt = CA'(t) - 1'b1;
                        if (take && !addr_ok(t, CODE_DEPTH)) begin
                            n_halt = 1'b1; n_stat = ST_ADDR;
                        end else begin
                            if (take) n_pc = tgt;
                            n_sp = SP'(newsp);
                        end
                    end
                    OP_OUT: begin n_oval = 1'b1; n_outv = r_top; end
                    OP_IN: res = r_val;
                    default: ;
                endcase
                if (info.push && n_state == S_DONE && n_stat == ST_OK) begin
                    s_we = 1'b1; s_wa = SA'(newsp - 1'b1); s_wd = res;
                end
                if (n_stat == ST_OK && n_state == S_DONE && r_op != OP_STORE
                    && r_op != OP_STI && r_op != OP_BR && r_op != OP_BRL
                    && r_op != OP_BRF)
                    n_sp = SP'(newsp);
            end
            S_DMEM: begin
                s_we = 1'b1; s_wa = SA'(r_sp - SP'(info.pops)); s_wd = r_dq;
                n_sp = r_sp - SP'(info.pops) + 1'b1;
                n_state = S_DONE;
            end
            S_DIV: if (div_done) begin
                s_we = 1'b1; s_wa = SA'(r_sp - 2'd2); s_wd = div_q;
                n_sp = r_sp - 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_ovalid = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid           = r_ovalid;
    assign o_out_valid       = r_oval;
    assign o_out_value       = r_oval ? 32'(signed'(r_outv)) : '0;
    assign o_status          = r_stat;
    assign o_program_counter = 10'(r_pc);
    assign o_stack_depth     = 8'(r_sp);
endmodule
`default_nettype wire

// ----- rtl/smc_checker.sv -----
// Port checker for the stack machine core and its bind.
`default_nettype none
module smc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic        o_out_valid,
    input wire logic [2:0]  o_status,
    input wire logic [7:0]  o_stack_depth
);
    import smc_pkg::*;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_stack_depth))
        else $error("result changed under stall");
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second word taken while busy");
    a_out_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_valid |-> o_status == ST_OK)
        else $error("out value with fault status");
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind stack_machine_core smc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_out_valid(o_out_valid),
    .o_status(o_status), .o_stack_depth(o_stack_depth)
);
`default_nettype wire
